### design/psbt_pkg.sv
// psbt_pkg: shared types and constants for the power switch budget timer.
// Used by psbt_update and power_switch_budget_timer. No dependencies.
package psbt_pkg;

    localparam int SEC_W   = 16;
    localparam int TPS_W   = 6;
    localparam int BLINK_W = 3;

    localparam logic [SEC_W-1:0]   STEP_RESET      = 16'd1800;
    localparam logic [TPS_W-1:0]   TPS_RESET       = 6'd20;
    localparam logic [SEC_W-1:0]   REBASE_AT       = 16'd50000;
    localparam logic [SEC_W-1:0]   REBASE_BY       = 16'd25000;
    localparam logic [SEC_W-1:0]   BUDGET_MAX      = 16'd65535;
    localparam logic [BLINK_W-1:0] OFF_BLINK_LIMIT = 3'd4;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    localparam logic CFG_STEP_SECONDS     = 1'b0;
    localparam logic CFG_TICKS_PER_SECOND = 1'b1;

    typedef struct packed {
        logic [SEC_W-1:0] step_seconds;
        logic [TPS_W-1:0] ticks_per_second;
    } cfg_t;

    typedef struct packed {
        logic kind;
        logic sw1_down;
        logic sw2_down;
    } item_t;

    typedef struct packed {
        logic [TPS_W-1:0]   tick_prescale;
        logic [SEC_W-1:0]   seconds_count;
        logic [SEC_W-1:0]   interval_start;
        logic [SEC_W-1:0]   budget_seconds;
        logic               press_latch;
        logic               switch_enabled;
        logic [BLINK_W-1:0] blink_count;
        logic               led_level;
    } state_t;

    localparam state_t STATE_RESET = '0;

endpackage

### design/power_switch_budget_timer.sv
// power_switch_budget_timer: top level with input register, state and result register.
// Depends on psbt_pkg and psbt_update.
//
//  channel | signals                                   | dir | notes
//  --------+-------------------------------------------+-----+-------------------------
//  in      | in_valid in_ready kind sw1_down sw2_down  | in  | tick or button poll request
//  out     | out_valid out_ready power_on led_on        | out | one result per request
//          | time_budget                               |     |
//  cfg     | cfg_write cfg_index cfg_data              | in  | 0 step_seconds, 1 ticks/sec
//
// One request per clock while results are taken; a result is valid once its request has moved to the result register.
// Request sits in the input register, the update is applied as it moves to the result register.
// A held result stalls the input register only once it too is full.
// Reset clears all timer state and loads step 1800, 20 ticks per second.
module power_switch_budget_timer
    import psbt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             kind,
    input  logic             sw1_down,
    input  logic             sw2_down,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             power_on,
    output logic             led_on,
    output logic [SEC_W-1:0] time_budget,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [SEC_W-1:0] cfg_data
);

    logic   in_valid_reg;
    item_t  item_reg;
    logic   out_valid_reg;
    state_t state_reg;
    state_t state_next;
    cfg_t   cfg_reg;
    logic   advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    psbt_update u_update (
        .cur  (state_reg),
        .item (item_reg),
        .cfg  (cfg_reg),
        .nxt  (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_seconds     <= STEP_RESET;
            cfg_reg.ticks_per_second <= TPS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_STEP_SECONDS:     cfg_reg.step_seconds     <= cfg_data;
                CFG_TICKS_PER_SECOND: cfg_reg.ticks_per_second <= cfg_data[TPS_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{kind: kind, sw1_down: sw1_down, sw2_down: sw2_down};
        end
    end

    assign out_valid   = out_valid_reg;
    assign power_on    = state_reg.switch_enabled;
    assign led_on      = state_reg.led_level;
    assign time_budget = state_reg.budget_seconds;

    a_on_has_budget: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.switch_enabled |-> (state_reg.budget_seconds != '0))
        else $error("power on with zero budget");

    a_blink_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.blink_count < OFF_BLINK_LIMIT)
        else $error("blink count out of range");

    a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("update without result");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without request");

endmodule

### design/psbt_update.sv
// psbt_update: single-pass next-state logic for one tick or poll request.
// Depends on psbt_pkg.
module psbt_update
    import psbt_pkg::*;
(
    input  state_t cur,
    input  item_t  item,
    input  cfg_t   cfg,
    output state_t nxt
);

    logic [TPS_W-1:0]   pre_inc;
    logic [BLINK_W-1:0] blink_tmp;
    logic [SEC_W:0]     budget_sum;
    logic [SEC_W-1:0]   elapsed;

    always_comb
    begin
        nxt        = cur;
        pre_inc    = cur.tick_prescale + 1'b1;
        blink_tmp  = cur.blink_count + 1'b1;
        budget_sum = '0;
        elapsed    = '0;

        if (item.kind == KIND_TICK)
        begin
            nxt.tick_prescale = pre_inc;
            if (pre_inc == cfg.ticks_per_second)
            begin
                nxt.tick_prescale = '0;
                nxt.seconds_count = cur.seconds_count + 1'b1;
                if (cur.switch_enabled)
                begin
                    nxt.led_level = ~cur.led_level;
                    blink_tmp     = '0;
                end
                else
                begin
                    blink_tmp = blink_tmp + 1'b1;
                end
                if (blink_tmp >= OFF_BLINK_LIMIT)
                begin
                    nxt.led_level = ~nxt.led_level;
                    blink_tmp     = '0;
                end
                nxt.blink_count = blink_tmp;
            end
        end
        else
        begin
            // subtract button wins; latch then blocks the add button
            if (item.sw1_down && !cur.press_latch)
            begin
                nxt.press_latch    = 1'b1;
                nxt.switch_enabled = 1'b1;
                if (cur.budget_seconds >= cfg.step_seconds)
                begin
                    nxt.budget_seconds = cur.budget_seconds - cfg.step_seconds;
                end
                else
                begin
                    nxt.budget_seconds = '0;
                    nxt.switch_enabled = 1'b0;
                end
            end
            else if (item.sw2_down && !cur.press_latch)
            begin
                nxt.press_latch = 1'b1;
                budget_sum = {1'b0, cur.budget_seconds} + {1'b0, cfg.step_seconds};
                nxt.budget_seconds = budget_sum[SEC_W] ? BUDGET_MAX : budget_sum[SEC_W-1:0];
                if (!cur.switch_enabled)
                begin
                    nxt.interval_start = cur.seconds_count;
                    nxt.switch_enabled = 1'b1;
                end
            end
            if (!item.sw1_down && !item.sw2_down)
            begin
                nxt.press_latch = 1'b0;
            end
            elapsed = cur.seconds_count - nxt.interval_start;
            if (elapsed >= nxt.budget_seconds)
            begin
                nxt.switch_enabled = 1'b0;
                nxt.budget_seconds = '0;
            end
            if (cur.seconds_count >= REBASE_AT)
            begin
                nxt.seconds_count = cur.seconds_count - REBASE_BY;
                if (nxt.switch_enabled)
                begin
                    nxt.interval_start = nxt.interval_start - REBASE_BY;
                end
            end
        end
    end

endmodule
